// File: rtl/ladrc_controller_step_defines.svh
// ----------------------------------------------------------------------------
// ladrc controller step assertion macros
// shared assertion forms for the controller rtl
// ----------------------------------------------------------------------------
`ifndef LADRC_CONTROLLER_STEP_DEFINES_SVH
`define LADRC_CONTROLLER_STEP_DEFINES_SVH

// same-cycle implication
`define LADRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LADRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ladrc_pkg.sv
// ----------------------------------------------------------------------------
// ladrc package
// register indexes, reset values, fixed-point types and saturation helpers
// ----------------------------------------------------------------------------
package ladrc_pkg;

    typedef logic signed [47:0] q48_t;
    typedef logic signed [49:0] wide_t;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [2:0] REG_TRACK_SPEED   = 3'd0;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd1;
    localparam logic [2:0] REG_PLANT_GAIN    = 3'd2;
    localparam logic [2:0] REG_CTRL_BW       = 3'd3;
    localparam logic [2:0] REG_OBS_BW        = 3'd4;
    localparam logic [2:0] REG_UPPER_LIMIT   = 3'd5;
    localparam logic [2:0] REG_LOWER_LIMIT   = 3'd6;

    localparam logic [31:0] RST_TRACK_SPEED  = 32'd6553600;
    localparam logic [23:0] RST_STEP_SIZE    = 24'd83886;
    localparam logic [31:0] RST_PLANT_GAIN   = 32'd16384000;
    localparam logic [31:0] RST_CTRL_BW      = 32'd6553600;
    localparam logic [31:0] RST_OBS_BW       = 32'd13107200;
    localparam logic [14:0] RST_UPPER_LIMIT  = 15'd4000;
    localparam logic [14:0] RST_LOWER_LIMIT  = 15'd8000;

    localparam wide_t POS48_W = 50'sd140737488355327;
    localparam wide_t NEG48_W = -50'sd140737488355328;

    function automatic wide_t ext48(input q48_t x);
        return {{2{x[47]}}, x};
    endfunction

    function automatic q48_t sat48(input wide_t x);
        if (x > POS48_W)
        begin
            return POS48_W[47:0];
        end
        else if (x < NEG48_W)
        begin
            return NEG48_W[47:0];
        end
        return x[47:0];
    endfunction

endpackage

// File: rtl/ladrc_controller_step.sv
// ----------------------------------------------------------------------------
// ladrc controller step
// linear active disturbance rejection controller, one control step per
// transaction, built around a bit-serial multiplier and a bit-serial divider
// ----------------------------------------------------------------------------
//  channel   | signals                                  | carries
//  s_*       | s_tvalid s_tready s_tdata s_tuser        | target, measured, op
//  m_*       | m_tvalid m_tready m_tdata m_tuser        | drive, ref, disturbance
//  cfg_*     | cfg_valid cfg_ready cfg_index cfg_data   | register writes
//
//  a control step makes seventeen passes through the shared radix-2
//  multiplier and then a restoring divide that yields a 64-bit quotient
//  a clear op zeroes the observer states and the clamp flag and goes straight to output
//  rst_n clears all controller states and loads the register defaults
//  a finished result waits in the output register while the next
//  transaction is taken; the core stalls only when that register is full
// ----------------------------------------------------------------------------
`include "ladrc_controller_step_defines.svh"

module ladrc_controller_step
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // target[47:0], measured[95:48]
    input  logic         s_tuser,   // op[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // drive[31:0], tracked_reference[79:32],
                                    // disturbance_estimate[127:80]
    output logic         m_tuser,   // clamped[0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_WB     = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_DIVEND = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    localparam logic [4:0] STEP_R2   = 5'd0;
    localparam logic [4:0] STEP_W0SQ = 5'd1;
    localparam logic [4:0] STEP_G3   = 5'd2;
    localparam logic [4:0] STEP_KP   = 5'd3;
    localparam logic [4:0] STEP_M1   = 5'd4;
    localparam logic [4:0] STEP_M2   = 5'd5;
    localparam logic [4:0] STEP_V1   = 5'd6;
    localparam logic [4:0] STEP_V2   = 5'd7;
    localparam logic [4:0] STEP_M3   = 5'd8;
    localparam logic [4:0] STEP_BU   = 5'd9;
    localparam logic [4:0] STEP_M4   = 5'd10;
    localparam logic [4:0] STEP_M5   = 5'd11;
    localparam logic [4:0] STEP_Z1   = 5'd12;
    localparam logic [4:0] STEP_Z2   = 5'd13;
    localparam logic [4:0] STEP_Z3   = 5'd14;
    localparam logic [4:0] STEP_M6   = 5'd15;
    localparam logic [4:0] STEP_M7   = 5'd16;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  step_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] track_speed_reg, plant_gain_reg, ctrl_bw_reg, obs_bw_reg;
    logic [23:0] step_size_reg;
    logic [14:0] upper_limit_reg, lower_limit_reg;

    ladrc_pkg::q48_t tgt_reg, meas_reg;
    ladrc_pkg::q48_t refp_reg, refv_reg, z1_reg, z2_reg, z3_reg;
    logic signed [31:0] last_drive_reg;
    logic        clip_reg;

    logic [63:0] r2_reg, w0sq_reg, g3_reg, kp_reg;
    ladrc_pkg::q48_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, bu_reg;

    logic [63:0]  mul_a_reg, mul_b_reg, res_reg;
    logic         mul_neg_reg, mul_s24_reg, mul_uns_reg;
    logic [127:0] acc_reg;

    logic [63:0] div_q_reg;
    logic [31:0] div_rem_reg, div_d_reg;
    logic        div_neg_reg;

    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic         m_tuser_reg;

    logic in_fire, cfg_fire, out_free;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // operand selection for the multiplier
    logic signed [48:0] op_x;
    logic [48:0]        op_mag;
    logic [63:0]        op_a, op_g, g1, g2;
    logic               op_s24, op_uns;
    ladrc_pkg::q48_t    e_obs;

    always_comb
    begin
        g1     = {32'b0, obs_bw_reg} + {31'b0, obs_bw_reg, 1'b0};
        g2     = w0sq_reg + {w0sq_reg[62:0], 1'b0};
        e_obs  = ladrc_pkg::sat48(ladrc_pkg::ext48(z1_reg) - ladrc_pkg::ext48(meas_reg));
        op_x   = '0;
        op_a   = '0;
        op_g   = '0;
        op_s24 = 1'b0;
        op_uns = 1'b0;
        case (step_reg)
            STEP_R2:
            begin
                op_uns = 1'b1;
                op_a   = {32'b0, track_speed_reg};
                op_g   = {32'b0, track_speed_reg};
            end
            STEP_W0SQ:
            begin
                op_uns = 1'b1;
                op_a   = {32'b0, obs_bw_reg};
                op_g   = {32'b0, obs_bw_reg};
            end
            STEP_G3:
            begin
                op_uns = 1'b1;
                op_a   = w0sq_reg;
                op_g   = {32'b0, obs_bw_reg};
            end
            STEP_KP:
            begin
                op_uns = 1'b1;
                op_a   = {32'b0, ctrl_bw_reg};
                op_g   = {32'b0, ctrl_bw_reg};
            end
            STEP_M1:
            begin
                op_x = 49'(ladrc_pkg::sat48(ladrc_pkg::ext48(refp_reg)
                           - ladrc_pkg::ext48(tgt_reg)));
                op_g = r2_reg;
            end
            STEP_M2:
            begin
                op_x = 49'(refv_reg);
                op_g = {31'b0, track_speed_reg, 1'b0};
            end
            STEP_V1:
            begin
                op_x   = 49'(refv_reg);
                op_g   = {40'b0, step_size_reg};
                op_s24 = 1'b1;
            end
            STEP_V2:
            begin
                op_x   = 49'(ladrc_pkg::sat48(-ladrc_pkg::ext48(m1_reg)
                             - ladrc_pkg::ext48(m2_reg)));
                op_g   = {40'b0, step_size_reg};
                op_s24 = 1'b1;
            end
            STEP_M3:
            begin
                op_x = 49'(e_obs);
                op_g = g1;
            end
            STEP_BU:
            begin
                op_x = 49'(last_drive_reg);
                op_g = {32'b0, plant_gain_reg};
            end
            STEP_M4:
            begin
                op_x = 49'(e_obs);
                op_g = g2;
            end
            STEP_M5:
            begin
                op_x = 49'(e_obs);
                op_g = g3_reg;
            end
            STEP_Z1:
            begin
                op_x   = 49'(ladrc_pkg::sat48(ladrc_pkg::ext48(z2_reg)
                             - ladrc_pkg::ext48(m3_reg)));
                op_g   = {40'b0, step_size_reg};
                op_s24 = 1'b1;
            end
            STEP_Z2:
            begin
                op_x   = 49'(ladrc_pkg::sat48(ladrc_pkg::ext48(z3_reg)
                             - ladrc_pkg::ext48(m4_reg) + ladrc_pkg::ext48(bu_reg)));
                op_g   = {40'b0, step_size_reg};
                op_s24 = 1'b1;
            end
            STEP_Z3:
            begin
                op_x   = -49'(m5_reg);
                op_g   = {40'b0, step_size_reg};
                op_s24 = 1'b1;
            end
            STEP_M6:
            begin
                op_x = 49'(ladrc_pkg::sat48(ladrc_pkg::ext48(refp_reg)
                           - ladrc_pkg::ext48(z1_reg)));
                op_g = kp_reg;
            end
            STEP_M7:
            begin
                op_x = 49'(ladrc_pkg::sat48(ladrc_pkg::ext48(refv_reg)
                           - ladrc_pkg::ext48(z2_reg)));
                op_g = {31'b0, ctrl_bw_reg, 1'b0};
            end
            default:
            begin
                op_x = '0;
            end
        endcase
        op_mag = op_x[48] ? 49'(-op_x) : 49'(op_x);
        if (!op_uns)
        begin
            op_a = {15'b0, op_mag};
        end
    end

    // serial multiply step and rounding
    logic [64:0]  mul_sum;
    logic [127:0] rnd, shifted;
    logic [63:0]  cap, rounded;

    always_comb
    begin
        mul_sum = {1'b0, acc_reg[127:64]} + (mul_b_reg[0] ? {1'b0, mul_a_reg} : 65'b0);
        rnd     = acc_reg + (mul_s24_reg ? 128'h80_0000 : 128'h8000);
        shifted = mul_s24_reg ? (rnd >> 24) : (rnd >> 16);
        cap     = mul_uns_reg ? 64'hFFFF_FFFF_FFFF_FFFF
                : (mul_neg_reg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF);
        rounded = ((|shifted[127:64]) || (shifted[63:0] > cap)) ? cap : shifted[63:0];
    end

    // signed result, numerator, divide step and limit clamp
    ladrc_pkg::q48_t  sres, num;
    logic [47:0]      num_mag;
    logic [32:0]      rs;
    logic             ge;
    logic [30:0]      lim;
    logic [63:0]      qclip;
    logic             over;

    always_comb
    begin
        sres    = mul_neg_reg ? -res_reg[47:0] : res_reg[47:0];
        num     = ladrc_pkg::sat48(ladrc_pkg::ext48(ladrc_pkg::sat48(
                      ladrc_pkg::ext48(m6_reg) + ladrc_pkg::ext48(sres)))
                  - ladrc_pkg::ext48(z3_reg));
        num_mag = num[47] ? -num : num;
        rs      = {div_rem_reg, div_q_reg[63]};
        ge      = rs >= {1'b0, div_d_reg};
        lim     = {div_neg_reg ? lower_limit_reg : upper_limit_reg, 16'b0};
        over    = div_q_reg > {33'b0, lim};
        qclip   = over ? {33'b0, lim} : div_q_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (s_tuser == ladrc_pkg::OP_CLEAR) ? ST_DONE : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_MUL;
            ST_MUL:    state_next = (cnt_reg == 6'd63) ? ST_ROUND : ST_MUL;
            ST_ROUND:  state_next = ST_WB;
            ST_WB:     state_next = (step_reg == STEP_M7) ? ST_DIV : ST_LOAD;
            ST_DIV:    state_next = (cnt_reg == 6'd63) ? ST_DIVEND : ST_DIV;
            ST_DIVEND: state_next = ST_DONE;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= STEP_R2;
            cnt_reg         <= '0;
            track_speed_reg <= ladrc_pkg::RST_TRACK_SPEED;
            step_size_reg   <= ladrc_pkg::RST_STEP_SIZE;
            plant_gain_reg  <= ladrc_pkg::RST_PLANT_GAIN;
            ctrl_bw_reg     <= ladrc_pkg::RST_CTRL_BW;
            obs_bw_reg      <= ladrc_pkg::RST_OBS_BW;
            upper_limit_reg <= ladrc_pkg::RST_UPPER_LIMIT;
            lower_limit_reg <= ladrc_pkg::RST_LOWER_LIMIT;
            refp_reg        <= '0;
            refv_reg        <= '0;
            z1_reg          <= '0;
            z2_reg          <= '0;
            z3_reg          <= '0;
            last_drive_reg  <= '0;
            clip_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                case (cfg_index)
                    ladrc_pkg::REG_TRACK_SPEED: track_speed_reg <= cfg_data;
                    ladrc_pkg::REG_STEP_SIZE:   step_size_reg   <= cfg_data[23:0];
                    ladrc_pkg::REG_PLANT_GAIN:  plant_gain_reg  <= cfg_data;
                    ladrc_pkg::REG_CTRL_BW:     ctrl_bw_reg     <= cfg_data;
                    ladrc_pkg::REG_OBS_BW:      obs_bw_reg      <= cfg_data;
                    ladrc_pkg::REG_UPPER_LIMIT: upper_limit_reg <= cfg_data[14:0];
                    ladrc_pkg::REG_LOWER_LIMIT: lower_limit_reg <= cfg_data[14:0];
                    default:                    ;
                endcase
            end
            if (m_tvalid_reg && m_tready && !((state_reg == ST_DONE) && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= STEP_R2;
                    if (in_fire && (s_tuser == ladrc_pkg::OP_CLEAR))
                    begin
                        z1_reg   <= '0;
                        z2_reg   <= '0;
                        z3_reg   <= '0;
                        clip_reg <= 1'b0;
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg <= '0;
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_WB:
                begin
                    step_reg <= step_reg + 5'd1;
                    cnt_reg  <= '0;
                    case (step_reg)
                        STEP_V1: refp_reg <= ladrc_pkg::sat48(ladrc_pkg::ext48(refp_reg)
                                                 + ladrc_pkg::ext48(sres));
                        STEP_V2: refv_reg <= ladrc_pkg::sat48(ladrc_pkg::ext48(refv_reg)
                                                 + ladrc_pkg::ext48(sres));
                        STEP_Z1: z1_reg   <= ladrc_pkg::sat48(ladrc_pkg::ext48(z1_reg)
                                                 + ladrc_pkg::ext48(sres));
                        STEP_Z2: z2_reg   <= ladrc_pkg::sat48(ladrc_pkg::ext48(z2_reg)
                                                 + ladrc_pkg::ext48(sres));
                        STEP_Z3: z3_reg   <= ladrc_pkg::sat48(ladrc_pkg::ext48(z3_reg)
                                                 + ladrc_pkg::ext48(sres));
                        default: ;
                    endcase
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_DIVEND:
                begin
                    clip_reg       <= over;
                    last_drive_reg <= div_neg_reg ? -qclip[31:0] : qclip[31:0];
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tgt_reg  <= s_tdata[47:0];
            meas_reg <= s_tdata[95:48];
        end
        case (state_reg)
            ST_LOAD:
            begin
                mul_a_reg   <= op_a;
                mul_b_reg   <= op_g;
                mul_neg_reg <= op_x[48] && !op_uns;
                mul_s24_reg <= op_s24;
                mul_uns_reg <= op_uns;
                acc_reg     <= '0;
            end
            ST_MUL:
            begin
                acc_reg   <= {mul_sum, acc_reg[63:1]};
                mul_b_reg <= {1'b0, mul_b_reg[63:1]};
            end
            ST_ROUND:
            begin
                res_reg <= rounded;
            end
            ST_WB:
            begin
                case (step_reg)
                    STEP_R2:   r2_reg   <= res_reg;
                    STEP_W0SQ: w0sq_reg <= res_reg;
                    STEP_G3:   g3_reg   <= res_reg;
                    STEP_KP:   kp_reg   <= res_reg;
                    STEP_M1:   m1_reg   <= sres;
                    STEP_M2:   m2_reg   <= sres;
                    STEP_M3:   m3_reg   <= sres;
                    STEP_BU:   bu_reg   <= sres;
                    STEP_M4:   m4_reg   <= sres;
                    STEP_M5:   m5_reg   <= sres;
                    STEP_M6:   m6_reg   <= sres;
                    default:   ;
                endcase
                if (step_reg == STEP_M7)
                begin
                    div_q_reg   <= {num_mag, 16'b0} + {33'b0, plant_gain_reg[31:1]};
                    div_rem_reg <= '0;
                    div_d_reg   <= (plant_gain_reg == 32'd0) ? 32'd1 : plant_gain_reg;
                    div_neg_reg <= num[47];
                end
            end
            ST_DIV:
            begin
                div_rem_reg <= ge ? 32'(rs - {1'b0, div_d_reg}) : rs[31:0];
                div_q_reg   <= {div_q_reg[62:0], ge};
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {z3_reg, refp_reg, last_drive_reg};
                    m_tuser_reg <= clip_reg;
                end
            end
            default: ;
        endcase
    end

    `LADRC_ASSERT_NEXT(a_busy_after_accept, in_fire, state_reg != ST_IDLE, "idle after accept")
    `LADRC_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV, div_d_reg != 32'd0, "zero divisor")
    `LADRC_ASSERT_NOW(a_clamp_at_limit, m_tvalid_reg && m_tuser_reg,
        (m_tdata_reg[31:0] == {1'b0, upper_limit_reg, 16'b0})
        || (m_tdata_reg[31:0] == 32'(-{1'b0, lower_limit_reg, 16'b0})),
        "clamped drive off limit")

endmodule
